[hw/rtl/video_byte_pixel_decoder_assert.svh]
// assertion helpers shared by the decoder rtl
`ifndef VIDEO_BYTE_PIXEL_DECODER_ASSERT_SVH
`define VIDEO_BYTE_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication, held off during reset
`define VBPD_ASSERT_SAME(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("vbpd check failed");

// next-cycle implication, held off during reset
`define VBPD_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("vbpd check failed");

`endif

[hw/rtl/vbpd_pkg.sv]
package vbpd_pkg;

	// transaction kind on the input channel
	typedef enum logic {
		KIND_VIDEO = 1'b0,
		KIND_INK   = 1'b1
	} kind_t;

	// screen mode codes
	typedef enum logic [1:0] {
		SMODE_2PIX = 2'd0,
		SMODE_4PIX = 2'd1,
		SMODE_8PIX = 2'd2,
		SMODE_OFF  = 2'd3
	} screen_mode_t;

	// configuration register indexes
	localparam logic [1:0] REG_SCREEN_MODE = 2'd0;
	localparam logic [1:0] REG_BYTE_OFFSET = 2'd1;
	localparam logic [1:0] REG_LINE_OFFSET = 2'd2;

	// layout constants
	localparam logic [10:0] BLANK_START = 11'd2000;
	localparam logic [9:0]  LINE_WRAP   = 10'd400;
	localparam logic [9:0]  LINE_WRAP2  = 10'd800;
	localparam logic [6:0]  BYTES_ROW   = 7'd80;
	// off/80 = (off/16)/5, and n/5 = (n*205)>>10 for n below 125
	localparam logic [7:0]  RECIP5      = 8'd205;

	typedef struct packed {
		screen_mode_t screen_mode;
		logic [10:0]  byte_off;
		logic [8:0]   line_off;
	} cfg_t;

	// one queued work item: a video byte with its position, or an ink write
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  line;
		logic [9:0]  x;
		logic [7:0]  data;
		logic [3:0]  pen;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[hw/rtl/video_byte_pixel_decoder.sv]
// channel   handshake               payload
// in        in_valid / in_ready     mode, vram_offset, data_byte, pen_number
// out       out_valid / out_ready   screen_line, pixel_x, pixel_width, ink_value, last_pixel
// cfg       cfg_we                  cfg_index, cfg_data
//
// a video byte gives one pixel per cycle while the output is not stalled: 2, 4 or 8 pixels
// by screen mode, set by the pixel counter of the back end; an ink write gives no pixel.
// input reaches the first pixel through the classify stage, the queue, the current-byte and output registers.
// reset clears the queue, the pen table and the registers (screen mode 1).
// the queue lets the front keep taking transactions while the output stalls.
module video_byte_pixel_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [13:0] vram_offset,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  pen_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  screen_line,
	output logic [9:0]  pixel_x,
	output logic [2:0]  pixel_width,
	output logic [4:0]  ink_value,
	output logic        last_pixel,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import vbpd_pkg::*;

	`include "video_byte_pixel_decoder_assert.svh"

	cfg_t     cfg_q;
	q_stat_t  q_stat;
	q_entry_t push_entry;
	q_entry_t head;
	logic     push;
	logic     pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_mode <= SMODE_4PIX;
			cfg_q.byte_off    <= '0;
			cfg_q.line_off    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_MODE: cfg_q.screen_mode <= screen_mode_t'(cfg_data[1:0]);
				REG_BYTE_OFFSET: cfg_q.byte_off    <= cfg_data;
				REG_LINE_OFFSET: cfg_q.line_off    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	vbpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.vram_offset (vram_offset),
		.data_byte   (data_byte),
		.pen_number  (pen_number),
		.cfg         (cfg_q),
		.q_stat      (q_stat),
		.push        (push),
		.entry       (push_entry)
	);

	vbpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	vbpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.screen_line (screen_line),
		.pixel_x     (pixel_x),
		.pixel_width (pixel_width),
		.ink_value   (ink_value),
		.last_pixel  (last_pixel)
	);

	// queue never overruns or underruns
	`VBPD_ASSERT_SAME(a_no_push_full, clk, arst_n, push, !q_stat.full)
	`VBPD_ASSERT_SAME(a_no_pop_empty, clk, arst_n, pop, !q_stat.empty)
	// the final pixel of a byte ends on the byte's right edge
	`VBPD_ASSERT_SAME(a_last_edge, clk, arst_n, out_valid && last_pixel, ({1'b0, pixel_x[2:0]} + {1'b0, pixel_width}) == 4'd8)
	// pixels stay on the visible screen
	`VBPD_ASSERT_SAME(a_on_screen, clk, arst_n, out_valid, (screen_line < 8'd200) && (pixel_x < 10'd640))

endmodule

[hw/rtl/vbpd_front.sv]
module vbpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [13:0]       vram_offset,
	input  logic [7:0]        data_byte,
	input  logic [3:0]        pen_number,
	input  vbpd_pkg::cfg_t    cfg,
	input  vbpd_pkg::q_stat_t q_stat,
	output logic              push,
	output vbpd_pkg::q_entry_t entry
);
	import vbpd_pkg::*;

	logic        is_ink;
	logic [10:0] off;
	logic        keep;
	logic        valid_s1;
	kind_t       kind_s1;
	logic [10:0] off_s1;
	logic [2:0]  bank_s1;
	logic [7:0]  data_s1;
	logic [3:0]  pen_s1;
	logic [14:0] prod;
	logic [4:0]  row;
	logic [10:0] row_bytes;
	logic [10:0] col_full;
	logic [9:0]  line_full;
	logic [9:0]  line_wrap;

	// scroll within the bank and drop video bytes that give no pixels
	assign is_ink = (mode == KIND_INK);
	assign off    = vram_offset[10:0] - cfg.byte_off;
	assign keep   = is_ink || ((off < BLANK_START) && (cfg.screen_mode != SMODE_OFF));

	assign in_ready = !valid_s1 || !q_stat.full;
	assign push     = valid_s1 && !q_stat.full;

	// classify stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= is_ink ? KIND_INK : KIND_VIDEO;
			off_s1  <= off;
			bank_s1 <= vram_offset[13:11];
			data_s1 <= data_byte;
			pen_s1  <= pen_number;
		end
	end

	// character row and column of the scrolled offset
	assign prod      = 15'(off_s1[10:4]) * 15'(RECIP5);
	assign row       = prod[14:10];
	assign row_bytes = 11'(row) * 11'(BYTES_ROW);
	assign col_full  = off_s1 - row_bytes;

	// line with scroll, wrapped at 400 lines
	assign line_full = {6'd0, bank_s1, 1'b0} + {1'b0, row, 4'd0} + {1'b0, cfg.line_off};
	always_comb begin
		if (line_full >= LINE_WRAP2) begin
			line_wrap = line_full - LINE_WRAP2;
		end else if (line_full >= LINE_WRAP) begin
			line_wrap = line_full - LINE_WRAP;
		end else begin
			line_wrap = line_full;
		end
	end

	always_comb begin
		entry.kind = kind_s1;
		entry.line = line_wrap[8:1];
		entry.x    = {col_full[6:0], 3'd0};
		entry.data = data_s1;
		entry.pen  = pen_s1;
	end

endmodule

[hw/rtl/vbpd_queue.sv]
module vbpd_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  vbpd_pkg::q_entry_t push_entry,
	input  logic               pop,
	output vbpd_pkg::q_entry_t head,
	output vbpd_pkg::q_stat_t  stat
);
	import vbpd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[hw/rtl/vbpd_back.sv]
module vbpd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  vbpd_pkg::cfg_t     cfg,
	input  vbpd_pkg::q_entry_t head,
	input  vbpd_pkg::q_stat_t  q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         screen_line,
	output logic [9:0]         pixel_x,
	output logic [2:0]         pixel_width,
	output logic [4:0]         ink_value,
	output logic               last_pixel
);
	import vbpd_pkg::*;

	logic       cur_valid_q;
	logic [7:0] cur_line_q;
	logic [9:0] cur_x_q;
	logic [7:0] cur_data_q;
	logic [2:0] pix_q;
	logic [4:0] pen_ink_q [16];

	logic       advance;
	logic       is_last;
	logic       finish;
	logic [2:0] last_idx;
	logic [2:0] width;
	logic [9:0] x_step;
	logic [7:0] data_sh;
	logic [3:0] pen;

	// per-mode pixel count, width, step and pen bits
	always_comb begin
		data_sh = cur_data_q << pix_q;
		case (cfg.screen_mode)
			SMODE_2PIX: begin
				last_idx = 3'd1;
				width    = 3'd4;
				x_step   = {5'd0, pix_q, 2'd0};
				pen      = pix_q[0] ? {cur_data_q[0], cur_data_q[4], cur_data_q[2], cur_data_q[6]}
				                    : {cur_data_q[1], cur_data_q[5], cur_data_q[3], cur_data_q[7]};
			end
			SMODE_4PIX: begin
				last_idx = 3'd3;
				width    = 3'd2;
				x_step   = {6'd0, pix_q, 1'b0};
				pen      = {2'd0, data_sh[3], data_sh[7]};
			end
			default: begin
				last_idx = 3'd7;
				width    = 3'd1;
				x_step   = {7'd0, pix_q};
				pen      = {3'd0, data_sh[7]};
			end
		endcase
	end

	assign advance = cur_valid_q && (!out_valid || out_ready);
	assign is_last = (pix_q == last_idx);
	assign finish  = advance && is_last;
	assign pop     = !q_stat.empty && (!cur_valid_q || finish);

	// current byte and pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pix_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= (head.kind == KIND_VIDEO);
			pix_q       <= '0;
		end else if (finish) begin
			cur_valid_q <= 1'b0;
		end else if (advance) begin
			pix_q <= pix_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_line_q <= head.line;
			cur_x_q    <= head.x;
			cur_data_q <= head.data;
		end
	end

	// pen table, written in transaction order behind earlier bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				pen_ink_q[i] <= '0;
			end
		end else if (pop && (head.kind == KIND_INK)) begin
			pen_ink_q[head.pen] <= head.data[4:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			screen_line <= cur_line_q;
			pixel_x     <= cur_x_q + x_step;
			pixel_width <= width;
			ink_value   <= pen_ink_q[pen];
			last_pixel  <= is_last;
		end
	end

endmodule
